[sv/qte_pkg.sv]
`timescale 1ns / 1ps

package qte_pkg;

	localparam int QUAT_WIDTH_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// Square root steps: one result bit per step, for radicands up to 2^60.
	localparam int ISQRT_STEPS = 31;
	localparam int ISQRT_VW    = 62;

	// CORDIC datapath width and angle constants (angles in units of 2^-30 rad).
	localparam int ANG_W = 34;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	localparam int ROLL_W  = 16;
	localparam int PITCH_W = 15;
	localparam int YAW_W   = 16;
	localparam int OUT_TD_W = 48;

	localparam int PI_Q13      = 25736;
	localparam int HALF_PI_Q13 = 12868;

	// Truncated arctangent of 2^-k in units of 2^-30 rad.
	function automatic logic [29:0] atan_tab(input logic [4:0] k);
		logic [29:0] r;
		case (k)
			5'd0:  r = 30'h3243F6A8;
			5'd1:  r = 30'h1DAC6705;
			5'd2:  r = 30'h0FADBAFC;
			5'd3:  r = 30'h07F56EA6;
			5'd4:  r = 30'h03FEAB76;
			5'd5:  r = 30'h01FFD55B;
			5'd6:  r = 30'h00FFFAAA;
			5'd7:  r = 30'h007FFF55;
			5'd8:  r = 30'h003FFFEA;
			5'd9:  r = 30'h001FFFFD;
			5'd10: r = 30'h000FFFFF;
			5'd11: r = 30'h0007FFFF;
			5'd12: r = 30'h0003FFFF;
			5'd13: r = 30'h0001FFFF;
			5'd14: r = 30'h0000FFFF;
			5'd15: r = 30'h00007FFF;
			5'd16: r = 30'h00003FFF;
			5'd17: r = 30'h00001FFF;
			5'd18: r = 30'h00000FFF;
			5'd19: r = 30'h000007FF;
			5'd20: r = 30'h000003FF;
			5'd21: r = 30'h000001FF;
			5'd22: r = 30'h000000FF;
			5'd23: r = 30'h0000007F;
			5'd24: r = 30'h0000003F;
			5'd25: r = 30'h0000001F;
			5'd26: r = 30'h0000000F;
			5'd27: r = 30'h00000008;
			5'd28: r = 30'h00000004;
			5'd29: r = 30'h00000002;
			5'd30: r = 30'h00000001;
			default: r = 30'h00000000;
		endcase
		return r;
	endfunction

endpackage

[sv/qte_isqrt.sv]
`timescale 1ns / 1ps

module qte_isqrt #(
	parameter int TAG_W = 1
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [qte_pkg::ISQRT_VW-1:0]         v_in,
	input  logic [TAG_W-1:0]                     tag_in,
	output logic [qte_pkg::ISQRT_STEPS-1:0]      root,
	output logic [TAG_W-1:0]                     tag_out
);
	import qte_pkg::*;

	localparam int N  = ISQRT_STEPS;
	localparam int VW = ISQRT_VW;

	logic [VW-1:0]    rem_s [0:N];
	logic [VW-1:0]    acc_s [0:N];
	logic [TAG_W-1:0] tag_s [0:N];

	assign rem_s[0] = v_in;
	assign acc_s[0] = '0;
	assign tag_s[0] = tag_in;

	// One result bit per stage, trial bit running from 2^60 down to 2^0.
	for (genvar j = 0; j < N; j++) begin : g_step
		localparam logic [VW-1:0] BIT = VW'(1) << (2 * (N - 1 - j));
		logic [VW-1:0] trial;
		assign trial = acc_s[j] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[j+1] <= tag_s[j];
				if (rem_s[j] >= trial) begin
					rem_s[j+1] <= rem_s[j] - trial;
					acc_s[j+1] <= (acc_s[j] >> 1) + BIT;
				end else begin
					rem_s[j+1] <= rem_s[j];
					acc_s[j+1] <= acc_s[j] >> 1;
				end
			end
		end
	end

	assign root    = acc_s[N][N-1:0];
	assign tag_out = tag_s[N];

endmodule

[sv/qte_atan2.sv]
`timescale 1ns / 1ps

module qte_atan2 #(
	parameter int IN_W  = 32,
	parameter int STEPS = 16,
	parameter int OUT_W = 16,
	parameter int LIM   = 25736,
	parameter int TAG_W = 1
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [IN_W-1:0]  y_in,
	input  logic signed [IN_W-1:0]  x_in,
	input  logic [TAG_W-1:0]        tag_in,
	output logic signed [OUT_W-1:0] angle,
	output logic [TAG_W-1:0]        tag_out
);
	import qte_pkg::*;

	localparam int NW = $clog2(IN_W + 1);
	localparam int AW = ANG_W;

	// Stage 1: find the right shift that brings both operands below 2^30.
	logic [IN_W-1:0]        ax, ay, mag;
	logic [NW-1:0]          nbits, nshift;
	logic signed [IN_W-1:0] x_s1, y_s1;
	logic [NW-1:0]          n_s1;
	logic                   zero_s1;
	logic [TAG_W-1:0]       tag_s1;

	always_comb begin
		ax = x_in[IN_W-1] ? IN_W'(-x_in) : IN_W'(x_in);
		ay = y_in[IN_W-1] ? IN_W'(-y_in) : IN_W'(y_in);
		mag = ax | ay;
		nbits = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (mag[i]) begin
				nbits = NW'(i + 1);
			end
		end
		nshift = (nbits > NW'(30)) ? nbits - NW'(30) : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_in;
			y_s1    <= y_in;
			n_s1    <= nshift;
			zero_s1 <= (mag == '0);
			tag_s1  <= tag_in;
		end
	end

	// Stage 2: shift, then fold the left half-plane onto the right one.
	logic signed [IN_W-1:0] xsh, ysh;
	logic signed [AW-1:0]   xn, yn;
	logic signed [AW-1:0]   xc_s [0:STEPS];
	logic signed [AW-1:0]   yc_s [0:STEPS];
	logic signed [AW-1:0]   zc_s [0:STEPS];
	logic                   zero_s [0:STEPS];
	logic [TAG_W-1:0]       tag_s [0:STEPS];

	assign xsh = x_s1 >>> n_s1;
	assign ysh = y_s1 >>> n_s1;
	assign xn  = AW'(xsh);
	assign yn  = AW'(ysh);

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= zero_s1;
			tag_s[0]  <= tag_s1;
			if (xn < 0) begin
				if (yn >= 0) begin
					xc_s[0] <= yn;
					yc_s[0] <= -xn;
					zc_s[0] <= HALF_PI_Q30;
				end else begin
					xc_s[0] <= -yn;
					yc_s[0] <= xn;
					zc_s[0] <= -HALF_PI_Q30;
				end
			end else begin
				xc_s[0] <= xn;
				yc_s[0] <= yn;
				zc_s[0] <= '0;
			end
		end
	end

	// One vectoring iteration per stage.
	for (genvar k = 0; k < STEPS; k++) begin : g_iter
		localparam logic signed [AW-1:0] ATN = AW'(atan_tab(5'(k)));
		logic signed [AW-1:0] dx, dy;
		assign dx = yc_s[k] >>> k;
		assign dy = xc_s[k] >>> k;
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k+1] <= zero_s[k];
				tag_s[k+1]  <= tag_s[k];
				if (yc_s[k] > 0) begin
					xc_s[k+1] <= xc_s[k] + dx;
					yc_s[k+1] <= yc_s[k] - dy;
					zc_s[k+1] <= zc_s[k] + ATN;
				end else begin
					xc_s[k+1] <= xc_s[k] - dx;
					yc_s[k+1] <= yc_s[k] + dy;
					zc_s[k+1] <= zc_s[k] - ATN;
				end
			end
		end
	end

	// Final stage: round to Q3.13 and saturate.
	localparam logic signed [AW-18:0] LIM_P = (AW - 17)'(LIM);
	localparam logic signed [AW-18:0] LIM_N = (AW - 17)'(-LIM);
	logic signed [AW-1:0]  zr;
	logic signed [AW-18:0] zq;
	logic signed [OUT_W-1:0] angle_s;
	logic [TAG_W-1:0]      tag_o_s;

	assign zr = zc_s[STEPS] + AW'(65536);
	assign zq = zr[AW-1:17];

	always_ff @(posedge clk) begin
		if (en) begin
			tag_o_s <= tag_s[STEPS];
			if (zero_s[STEPS]) begin
				angle_s <= '0;
			end else if (zq > LIM_P) begin
				angle_s <= OUT_W'(LIM_P);
			end else if (zq < LIM_N) begin
				angle_s <= OUT_W'(LIM_N);
			end else begin
				angle_s <= OUT_W'(zq);
			end
		end
	end

	assign angle   = angle_s;
	assign tag_out = tag_o_s;

endmodule

[sv/quaternion_to_euler_angles_unit.sv]
`timescale 1ns / 1ps
// The pitch path, with the 31-stage square root and its CORDIC chain, is the longest path
// from input transfer to result.
// Throughput: one quaternion per cycle; a stall at the output freezes the whole pipeline.
// Reset (arst_n, asynchronous, active low) clears only the stage valid bits.

module quaternion_to_euler_angles_unit #(
	parameter int QUAT_WIDTH   = qte_pkg::QUAT_WIDTH_DEF,
	parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// quat_w, quat_x, quat_y, quat_z, then zero padding
	input  logic [((4*QUAT_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31], zero pad [47]
	output logic [qte_pkg::OUT_TD_W-1:0] m_tdata,
	// pitch_clamped
	output logic m_tuser
);
	import qte_pkg::*;

	localparam int QW  = QUAT_WIDTH;
	localparam int PW  = 2 * QW - 2;
	localparam int SW  = 2 * QW;
	localparam int WW  = SW + 12;
	localparam int D   = 2 * QW - 36;
	localparam int DR  = (D >= 0) ? D : 0;
	localparam int DL  = (D < 0) ? -D : 0;
	localparam int DLY = 2 + ISQRT_STEPS;
	localparam int L   = CORDIC_STEPS + 39;

	localparam logic signed [SW-1:0] ONE   = SW'(1) <<< (2 * QW - 6);
	localparam logic signed [WW-1:0] LIM_P = WW'(1) <<< 30;
	localparam logic signed [WW-1:0] LIM_N = -(WW'(1) <<< 30);
	localparam logic signed [63:0]   TWO60 = 64'sd1 <<< 60;

	logic en;
	logic [L-1:0] vld_q;

	assign en       = !vld_q[L-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], s_tvalid};
		end
	end

	function automatic logic signed [PW-1:0] mulq(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [SW-1:0] pr;
		pr = a * b;
		return pr[SW-1:2];
	endfunction

	logic signed [QW-1:0] qw, qx, qy, qz;
	assign qw = s_tdata[QW-1:0];
	assign qx = s_tdata[2*QW-1:QW];
	assign qy = s_tdata[3*QW-1:2*QW];
	assign qz = s_tdata[4*QW-1:3*QW];

	// Stage 1: the nine component products.
	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= mulq(qw, qx);
			yz_s1 <= mulq(qy, qz);
			xx_s1 <= mulq(qx, qx);
			yy_s1 <= mulq(qy, qy);
			wz_s1 <= mulq(qw, qz);
			xy_s1 <= mulq(qx, qy);
			zz_s1 <= mulq(qz, qz);
			wy_s1 <= mulq(qw, qy);
			zx_s1 <= mulq(qz, qx);
		end
	end

	// Stage 2: the sine and cosine terms.
	logic signed [PW:0]   sum_r, sum_cr, sum_y, sum_cy, dif_p;
	logic signed [SW-1:0] sr_s2, cr_s2, sy_s2, cy_s2, sp_s2;

	assign sum_r  = (PW + 1)'(wx_s1) + (PW + 1)'(yz_s1);
	assign sum_cr = (PW + 1)'(xx_s1) + (PW + 1)'(yy_s1);
	assign sum_y  = (PW + 1)'(wz_s1) + (PW + 1)'(xy_s1);
	assign sum_cy = (PW + 1)'(yy_s1) + (PW + 1)'(zz_s1);
	assign dif_p  = (PW + 1)'(wy_s1) - (PW + 1)'(zx_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2 <= {sum_r, 1'b0};
			cr_s2 <= ONE - {sum_cr, 1'b0};
			sy_s2 <= {sum_y, 1'b0};
			cy_s2 <= ONE - {sum_cy, 1'b0};
			sp_s2 <= {dif_p, 1'b0};
		end
	end

	// Stage 3: range check on the pitch sine and rescaling to 2^30.
	logic signed [WW-1:0] sp_ext, sp_sc;
	logic                 flag_s3, pos_s3;
	logic signed [31:0]   s30_s3;

	assign sp_ext = WW'(sp_s2);
	assign sp_sc  = (sp_ext >>> DR) <<< DL;

	always_ff @(posedge clk) begin
		if (en) begin
			flag_s3 <= (sp_s2 >= ONE) || (sp_s2 <= -ONE);
			pos_s3  <= (sp_s2 > 0);
			if (sp_sc >= LIM_P) begin
				s30_s3 <= 32'(LIM_P);
			end else if (sp_sc <= LIM_N) begin
				s30_s3 <= 32'(LIM_N);
			end else begin
				s30_s3 <= 32'(sp_sc);
			end
		end
	end

	// Stage 4: radicand for the cosine, 2^60 - s^2.
	logic signed [63:0]         sq;
	logic [ISQRT_VW-1:0]        v_s4;
	logic                       flag_s4, pos_s4;
	logic signed [31:0]         s30_s4;

	assign sq = s30_s3 * s30_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4    <= ISQRT_VW'(TWO60 - sq);
			flag_s4 <= flag_s3;
			pos_s4  <= pos_s3;
			s30_s4  <= s30_s3;
		end
	end

	logic [ISQRT_STEPS-1:0] root;
	logic [33:0]            sq_tag;
	logic signed [31:0]     s30_r;
	logic [1:0]             p_tag;

	qte_isqrt #(
		.TAG_W (34)
	) u_isqrt (
		.clk     (clk),
		.en      (en),
		.v_in    (v_s4),
		.tag_in  ({flag_s4, pos_s4, s30_s4}),
		.root    (root),
		.tag_out (sq_tag)
	);

	assign s30_r = sq_tag[31:0];

	logic signed [PITCH_W-1:0] pitch_a;

	qte_atan2 #(
		.IN_W  (32),
		.STEPS (CORDIC_STEPS),
		.OUT_W (PITCH_W),
		.LIM   (HALF_PI_Q13),
		.TAG_W (2)
	) u_pitch (
		.clk     (clk),
		.en      (en),
		.y_in    (s30_r),
		.x_in    ({1'b0, root}),
		.tag_in  (sq_tag[33:32]),
		.angle   (pitch_a),
		.tag_out (p_tag)
	);

	logic signed [ROLL_W-1:0] roll_a;
	logic signed [YAW_W-1:0]  yaw_a;
	logic                     roll_t, yaw_t;

	qte_atan2 #(
		.IN_W  (SW),
		.STEPS (CORDIC_STEPS),
		.OUT_W (ROLL_W),
		.LIM   (PI_Q13),
		.TAG_W (1)
	) u_roll (
		.clk     (clk),
		.en      (en),
		.y_in    (sr_s2),
		.x_in    (cr_s2),
		.tag_in  (1'b0),
		.angle   (roll_a),
		.tag_out (roll_t)
	);

	qte_atan2 #(
		.IN_W  (SW),
		.STEPS (CORDIC_STEPS),
		.OUT_W (YAW_W),
		.LIM   (PI_Q13),
		.TAG_W (1)
	) u_yaw (
		.clk     (clk),
		.en      (en),
		.y_in    (sy_s2),
		.x_in    (cy_s2),
		.tag_in  (roll_t),
		.angle   (yaw_a),
		.tag_out (yaw_t)
	);

	// Roll and yaw finish early; a delay line brings them level with pitch.
	logic [ROLL_W+YAW_W-1:0] ry_dly_s [0:DLY-1];

	always_ff @(posedge clk) begin
		if (en) begin
			ry_dly_s[0] <= {yaw_a, roll_a};
			for (int i = 1; i < DLY; i++) begin
				ry_dly_s[i] <= ry_dly_s[i-1];
			end
		end
	end

	// Output stage.
	logic [OUT_TD_W-1:0] tdata_s;
	logic                tuser_s;
	logic [PITCH_W-1:0]  pitch_f;

	always_comb begin
		if (p_tag[1]) begin
			pitch_f = p_tag[0] ? PITCH_W'(HALF_PI_Q13) : PITCH_W'(-HALF_PI_Q13);
		end else begin
			pitch_f = pitch_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_s <= {yaw_t, ry_dly_s[DLY-1][ROLL_W+YAW_W-1:ROLL_W], pitch_f,
				ry_dly_s[DLY-1][ROLL_W-1:0]};
			tuser_s <= p_tag[1];
		end
	end

	assign m_tdata = tdata_s;
	assign m_tuser = tuser_s;

endmodule

[sv/qte_checker.sv]
`timescale 1ns / 1ps

module qte_checker #(
	parameter int IN_TD_W = 64
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [IN_TD_W-1:0]            s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [qte_pkg::OUT_TD_W-1:0]  m_tdata,
	input logic                          m_tuser
);
	import qte_pkg::*;

	logic signed [ROLL_W-1:0]  roll_v;
	logic signed [PITCH_W-1:0] pitch_v;
	logic                      unused_in;

	assign roll_v    = m_tdata[ROLL_W-1:0];
	assign pitch_v   = m_tdata[ROLL_W+PITCH_W-1:ROLL_W];
	assign unused_in = s_tvalid ^ (^s_tdata);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn before transfer");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input refused with empty output");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			pitch_v == PITCH_W'(HALF_PI_Q13) || pitch_v == PITCH_W'(-HALF_PI_Q13))
		else $error("clamped pitch is not a right angle");

	a_roll: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> roll_v <= ROLL_W'(PI_Q13) && roll_v >= ROLL_W'(-PI_Q13))
		else $error("roll out of range");

endmodule

bind quaternion_to_euler_angles_unit qte_checker #(
	.IN_TD_W (((4*QUAT_WIDTH+7)/8)*8)
) u_qte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
